### design/assert_macros.svh
// Assertion macros used by khist_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds, consequent holds in the same cycle
`define AST_SAME(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");

// Antecedent holds, consequent holds in the next cycle
`define AST_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");

`endif

### design/khist_pkg.sv
// ----------------------------------------------------------------------------
// khist_pkg
// Types, constants and helpers of the key frequency histogram.
// ----------------------------------------------------------------------------
package khist_pkg;

  localparam int KH_ENTRIES = 64;
  localparam int KEY_W      = 64;
  localparam int CNT_W      = 32;
  localparam int ONES_W     = 7;
  localparam int RANK_W     = 6;
  localparam int USED_W     = 7;
  localparam int STATUS_W   = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [STATUS_W-1:0] ST_ENTRY = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_ADD,
    OP_LOAD,
    OP_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [KEY_W-1:0]    word;
    logic [ONES_W-1:0]   ones;
    logic [RANK_W-1:0]   rank_q;
  } cell_ctl_t;

  // Count token circulating round the ring
  typedef struct packed {
    logic              vld;
    logic [CNT_W-1:0]  cnt;
    logic [RANK_W-1:0] idx;
  } tok_t;

  typedef struct packed {
    logic              hit;
    logic              sel;
    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  cnt;
    logic [ONES_W-1:0] ones;
  } cell_out_t;

  function automatic logic [ONES_W-1:0] popcount(input logic [KEY_W-1:0] v);
    logic [ONES_W-1:0] n;
    n = '0;
    for (int b = 0; b < KEY_W; b++) begin
      n = n + ONES_W'(v[b]);
    end
    return n;
  endfunction

endpackage

### design/key_frequency_histogram_core.sv
// ----------------------------------------------------------------------------
// key_frequency_histogram_core
// Counts distinct 64-bit words and reads them out in ascending count order.
// ----------------------------------------------------------------------------
// An add is accepted, then every cell compares its key with the word and
// the hit cell counts, or the next free cell is filled, or the word is
// dropped with status FULL when the table is full. A report has the accept
// cycle, a load (one EMPTY result if the table is empty), ENTRIES-1 shifts
// of the count token round the ring of cells while each cell builds its
// rank, then one result per cycle in rank order. Results appear on out_* for
// one cycle with out_valid and cannot be held off; busy is high until the
// item is done.
module key_frequency_histogram_core import khist_pkg::*; #(
  parameter int ENTRIES = KH_ENTRIES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_mode,
  input  logic [KEY_W-1:0]    in_word,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [RANK_W-1:0]   out_rank,
  output logic [KEY_W-1:0]    out_key,
  output logic [CNT_W-1:0]    out_count,
  output logic [ONES_W-1:0]   out_ones,
  output logic                out_last
);

  typedef enum logic [2:0] {S_IDLE, S_ADD, S_LOAD, S_RANK, S_OUT} state_t;

  state_t              state_r;
  logic [KEY_W-1:0]    word_r;
  logic [ONES_W-1:0]   ones_r;
  logic [USED_W-1:0]   used_r;
  logic [RANK_W-1:0]   step_r;
  logic [RANK_W-1:0]   outq_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [RANK_W-1:0]   out_rank_r;
  logic [KEY_W-1:0]    out_key_r;
  logic [CNT_W-1:0]    out_count_r;
  logic [ONES_W-1:0]   out_ones_r;
  logic                out_last_r;

  cell_ctl_t           ctl;
  cell_out_t           couts [ENTRIES];
  tok_t                toks  [ENTRIES];
  logic [ENTRIES-1:0]  hits;
  logic                any_hit;
  logic [KEY_W-1:0]    sel_key;
  logic [CNT_W-1:0]    sel_cnt;
  logic [ONES_W-1:0]   sel_ones;

  always_comb begin
    ctl.word   = word_r;
    ctl.ones   = ones_r;
    ctl.rank_q = outq_r;
    unique case (state_r)
      S_ADD:   ctl.op = OP_ADD;
      S_LOAD:  ctl.op = OP_LOAD;
      S_RANK:  ctl.op = OP_SHIFT;
      default: ctl.op = OP_NOP;
    endcase
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic append_en;
    assign append_en = (state_r == S_ADD) && !any_hit && (used_r == USED_W'(i));
    khist_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .append_en(append_en),
      .tok_in   (toks[(i + ENTRIES - 1) % ENTRIES]),
      .tok_out  (toks[i]),
      .cout     (couts[i])
    );
    assign hits[i] = couts[i].hit;
  end

  assign any_hit = |hits;

  always_comb begin
    sel_key  = '0;
    sel_cnt  = '0;
    sel_ones = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      sel_key  = sel_key  | couts[i].key;
      sel_cnt  = sel_cnt  | couts[i].cnt;
      sel_ones = sel_ones | couts[i].ones;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            word_r  <= in_word;
            ones_r  <= popcount(in_word);
            state_r <= in_mode ? S_LOAD : S_ADD;
          end
        end
        S_ADD: begin
          if (!any_hit) begin
            if (used_r == USED_W'(ENTRIES)) begin
              // drop the word
              out_valid_r  <= 1'b1;
              out_status_r <= ST_FULL;
              out_rank_r   <= '0;
              out_key_r    <= word_r;
              out_count_r  <= '0;
              out_ones_r   <= ones_r;
              out_last_r   <= 1'b0;
            end else begin
              used_r <= used_r + USED_W'(1);
            end
          end
          state_r <= S_IDLE;
        end
        S_LOAD: begin
          if (used_r == '0) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_EMPTY;
            out_rank_r   <= '0;
            out_key_r    <= '0;
            out_count_r  <= '0;
            out_ones_r   <= '0;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end else begin
            step_r  <= '0;
            state_r <= S_RANK;
          end
        end
        S_RANK: begin
          step_r <= step_r + RANK_W'(1);
          if (step_r == RANK_W'(ENTRIES - 2)) begin
            outq_r  <= '0;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid_r  <= 1'b1;
          out_status_r <= ST_ENTRY;
          out_rank_r   <= outq_r;
          out_key_r    <= sel_key;
          out_count_r  <= sel_cnt;
          out_ones_r   <= sel_ones;
          out_last_r   <= (USED_W'(outq_r) == used_r - USED_W'(1));
          outq_r       <= outq_r + RANK_W'(1);
          if (USED_W'(outq_r) == used_r - USED_W'(1)) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_rank   = out_rank_r;
  assign out_key    = out_key_r;
  assign out_count  = out_count_r;
  assign out_ones   = out_ones_r;
  assign out_last   = out_last_r;

endmodule

### design/khist_cell.sv
// ----------------------------------------------------------------------------
// khist_cell
// One histogram entry: key, count and popcount, plus the rank accumulator
// fed by the count token passed from the neighbouring cell.
// ----------------------------------------------------------------------------
module khist_cell import khist_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  logic      append_en,
  input  tok_t      tok_in,
  output tok_t      tok_out,
  output cell_out_t cout
);

  logic              valid_r;
  logic [KEY_W-1:0]  key_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [ONES_W-1:0] ones_r;
  logic [RANK_W-1:0] rank_r;
  tok_t              tok_r;
  logic              hit;
  logic              sel;
  logic              ahead;

  localparam logic [RANK_W-1:0] MY_IDX = RANK_W'(IDX);

  assign hit = valid_r && (key_r == ctl.word);
  assign sel = valid_r && (rank_r == ctl.rank_q);
  // token entry sorts before this one
  assign ahead = tok_in.vld &&
                 ((tok_in.cnt < cnt_r) || ((tok_in.cnt == cnt_r) && (tok_in.idx < MY_IDX)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (append_en) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (append_en) begin
      key_r  <= ctl.word;
      cnt_r  <= CNT_W'(1);
      ones_r <= ctl.ones;
    end else if (ctl.op == OP_ADD && hit && cnt_r != CNT_MAX) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
    unique case (ctl.op)
      OP_LOAD: begin
        tok_r  <= '{vld: valid_r, cnt: cnt_r, idx: MY_IDX};
        rank_r <= '0;
      end
      OP_SHIFT: begin
        tok_r <= tok_in;
        if (ahead) begin
          rank_r <= rank_r + RANK_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign tok_out   = tok_r;
  assign cout.hit  = hit;
  assign cout.sel  = sel;
  assign cout.key  = sel ? key_r  : '0;
  assign cout.cnt  = sel ? cnt_r  : '0;
  assign cout.ones = sel ? ones_r : '0;

endmodule

### design/khist_checker.sv
// ----------------------------------------------------------------------------
// khist_checker
// Port-level checks on the histogram core, bound into the core module.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module khist_checker import khist_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input logic [STATUS_W-1:0] out_status,
  input logic [CNT_W-1:0]    out_count,
  input logic                out_last
);

  `AST_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `AST_SAME(a_status_code, clk, rst_n, out_valid,
    out_status == ST_ENTRY || out_status == ST_FULL || out_status == ST_EMPTY)
  `AST_SAME(a_empty_last, clk, rst_n, out_valid && out_status == ST_EMPTY, out_last)
  `AST_SAME(a_full_shape, clk, rst_n, out_valid && out_status == ST_FULL,
    !out_last && out_count == '0)
  `AST_SAME(a_entry_count, clk, rst_n, out_valid && out_status == ST_ENTRY,
    out_count != '0)

endmodule

bind key_frequency_histogram_core khist_checker u_khist_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_status(out_status),
  .out_count (out_count),
  .out_last  (out_last)
);

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for key_frequency_histogram_core. Words are added and
// sorted reports requested through the start/busy handshake. A model of the
// key table inside the bench predicts every report entry and every dropped
// word, and each word on out_* is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top import khist_pkg::*;;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int POOL_SIZE   = 80;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RANK_W-1:0]   rank;
    logic [KEY_W-1:0]    key;
    logic [CNT_W-1:0]    count;
    logic [ONES_W-1:0]   ones;
    logic                last;
  } hist_word_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_mode = 1'b0;
  logic [KEY_W-1:0]    in_word = '0;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [RANK_W-1:0]   out_rank;
  logic [KEY_W-1:0]    out_key;
  logic [CNT_W-1:0]    out_count;
  logic [ONES_W-1:0]   out_ones;
  logic                out_last;

  logic [KEY_W-1:0] tab_key [KH_ENTRIES];
  logic [CNT_W-1:0] tab_cnt [KH_ENTRIES];
  int               tab_used = 0;
  hist_word_t       pending_q[$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  int               error_count = 0;
  int               cycle_count = 0;
  int               idle_pct = 0;

  key_frequency_histogram_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_word(in_word),
    .out_valid(out_valid), .out_status(out_status), .out_rank(out_rank),
    .out_key(out_key), .out_count(out_count), .out_ones(out_ones),
    .out_last(out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Update the key table and queue the words this item should produce
  task automatic predict_histogram(input logic mode, input logic [KEY_W-1:0] word);
    hist_word_t r;
    int         rank;
    hist_word_t by_rank [KH_ENTRIES];
    if (mode == 1'b0) begin
      for (int i = 0; i < tab_used; i++) begin
        if (tab_key[i] == word) begin
          if (tab_cnt[i] != CNT_MAX) tab_cnt[i]++;
          return;
        end
      end
      if (tab_used >= KH_ENTRIES) begin
        r = '{ST_FULL, '0, word, '0, ONES_W'($countones(word)), 1'b0};
        pending_q.push_back(r);
      end else begin
        tab_key[tab_used] = word;
        tab_cnt[tab_used] = CNT_W'(1);
        tab_used++;
      end
    end else if (tab_used == 0) begin
      r = '{ST_EMPTY, '0, '0, '0, '0, 1'b1};
      pending_q.push_back(r);
    end else begin
      for (int i = 0; i < tab_used; i++) begin
        rank = 0;
        for (int j = 0; j < tab_used; j++) begin
          if (tab_cnt[j] < tab_cnt[i] || (tab_cnt[j] == tab_cnt[i] && j < i)) rank++;
        end
        by_rank[rank] = '{ST_ENTRY, RANK_W'(rank), tab_key[i], tab_cnt[i],
                          ONES_W'($countones(tab_key[i])), rank == tab_used - 1};
      end
      for (int k = 0; k < tab_used; k++) pending_q.push_back(by_rank[k]);
    end
  endtask

  // Check the result word first, then take any accepted item
  always @(posedge clk) begin
    hist_word_t w;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else if (rst_n) begin
      if (out_valid) begin
        if (pending_q.size() == 0) begin
          report_mismatch("unexpected result word");
        end else begin
          w = pending_q.pop_front();
          if (out_status !== w.status)
            report_mismatch($sformatf("status %0d want %0d", out_status, w.status));
          if (out_rank !== w.rank)
            report_mismatch($sformatf("rank %0d want %0d", out_rank, w.rank));
          if (out_key !== w.key)
            report_mismatch($sformatf("key %h want %h", out_key, w.key));
          if (out_count !== w.count)
            report_mismatch($sformatf("count %0d want %0d", out_count, w.count));
          if (out_ones !== w.ones)
            report_mismatch($sformatf("ones %0d want %0d", out_ones, w.ones));
          if (out_last !== w.last)
            report_mismatch($sformatf("last %0d want %0d", out_last, w.last));
        end
      end
      if (start && !busy) predict_histogram(in_mode, in_word);
    end
  end

  // Present one item and hold it until the block takes it
  task automatic send_item(input logic mode, input logic [KEY_W-1:0] word);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_mode <= mode;
    in_word <= word;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic test_empty_report();
    send_item(1'b1, rand_word());
    wait_drained();
  endtask

  // Field extremes, hits, ties in insertion order, word ignored on report
  task automatic test_directed();
    send_item(1'b0, '0);
    send_item(1'b0, '1);
    send_item(1'b0, 64'h8000_0000_0000_0001);
    send_item(1'b0, '1);
    send_item(1'b0, 64'h5555_5555_5555_5555);
    send_item(1'b0, '1);
    send_item(1'b0, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(1'b1, '1);
    send_item(1'b0, '0);
    send_item(1'b1, '0);
    wait_drained();
  endtask

  task automatic test_random(input int n_items);
    logic [KEY_W-1:0] w;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(14) == 0) begin
        send_item(1'b1, rand_word());
      end else begin
        w = ($urandom_range(4) == 0) ? rand_word() : key_pool[$urandom_range(POOL_SIZE - 1)];
        send_item(1'b0, w);
      end
    end
    wait_drained();
  endtask

  // Fill the table so misses are dropped, then read it out
  task automatic test_full_table();
    for (int i = 0; i < POOL_SIZE; i++) send_item(1'b0, key_pool[i]);
    send_item(1'b0, rand_word());
    send_item(1'b0, key_pool[0]);
    send_item(1'b1, '0);
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = rand_word();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_report();
    test_directed();
    idle_pct = 0;
    test_random(60);
    idle_pct = 58;
    test_random(60);
    // hold off until all expected results are out and the block is idle before the next burst
    wait_drained();
    idle_pct = 22;
    test_random(40);
    idle_pct = 0;
    test_full_table();
    idle_pct = 58;
    test_random(30);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/khist_pkg.sv
design/khist_cell.sv
design/key_frequency_histogram_core.sv
design/khist_checker.sv
tb/tb_top.sv
